/* rtl/core/sgm_path_cost_aggregation_unit_macros.svh */
// Assertion macros used by the checker file of the block.
`ifndef SGM_PATH_COST_AGGREGATION_UNIT_MACROS_SVH
`define SGM_PATH_COST_AGGREGATION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgm path cost aggregation assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgm path cost aggregation assertion failed");

`endif

/* rtl/core/sgmpca_pkg.sv */
package sgmpca_pkg;

   localparam int unsigned COST_WIDTH     = 8;
   localparam int unsigned P2_WIDTH       = 12;
   localparam int unsigned COUNT_WIDTH    = 9;
   localparam int unsigned DIVISOR_WIDTH  = 9;
   localparam int unsigned DIV_STEP_WIDTH = 4;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_SMALL_PENALTY      = 2'd0;
   localparam csr_index_type CSR_LARGE_PENALTY_BASE = 2'd1;
   localparam csr_index_type CSR_DISPARITY_COUNT    = 2'd2;

   localparam logic [COST_WIDTH-1:0] COST_TOP            = 8'hFF;
   localparam logic [COST_WIDTH-1:0] SMALL_PENALTY_RESET = 8'd10;
   localparam logic [P2_WIDTH-1:0]   LARGE_PENALTY_RESET = 12'd150;
   localparam logic [COST_WIDTH-1:0] COUNT_RESET         = 8'd64;
   localparam logic [DIV_STEP_WIDTH-1:0] DIV_LAST_STEP   = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_CALC = 3'b100
   } state_type;

endpackage

/* rtl/core/sgm_path_cost_aggregation_unit.sv */
// Aggregates semi-global-matching costs along one path, one request per pixel disparity,
// disparities of a pixel in ascending order. The idle state accepts a request and reads the
// previous pixel's costs at this and the next disparity from the cost memory; the compute
// state forms the aggregated cost in the adder and compare unit and writes it back. A pixel's
// first disparity first passes a divide state, where a restoring divider forms one quotient
// bit per cycle of the large penalty over the gray difference plus one. A result not taken
// holds the compute state until the output register frees. The cost memory is not cleared; the
// user, not the block, must see that an entry is read only after the previous pixel wrote it.
module sgm_path_cost_aggregation_unit #(
   parameter int unsigned MAX_DISPARITIES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_path_start,
   input  logic [7:0]             req_pixel_gray,
   input  logic [7:0]             req_initial_cost,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_aggregated_cost,
   output logic                   rsp_pixel_done,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sgmpca_pkg::csr_index_type csr_index,
   input  logic [11:0]            csr_data
);

   import sgmpca_pkg::*;

   localparam int unsigned IW = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;

   logic [COST_WIDTH-1:0] cost_mem [MAX_DISPARITIES];

   state_type state_ff, state_in;
   logic [COST_WIDTH-1:0] small_penalty_ff, small_penalty_in;
   logic [P2_WIDTH-1:0] large_base_ff, large_base_in;
   logic [COST_WIDTH-1:0] count_ff, count_in;
   logic [COST_WIDTH-1:0] prev_min_ff, prev_min_in;
   logic [COST_WIDTH-1:0] run_min_ff, run_min_in;
   logic [COST_WIDTH-1:0] held_lower_ff, held_lower_in;
   logic [COST_WIDTH-1:0] prev_gray_ff, prev_gray_in;
   logic [P2_WIDTH-1:0] large_pen_ff, large_pen_in;
   logic [IW-1:0] disp_ff, disp_in;
   logic first_ff, first_in;
   logic [COST_WIDTH-1:0] cost_ff, cost_in;
   logic [DIVISOR_WIDTH-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [P2_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_STEP_WIDTH-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COST_WIDTH-1:0] rsp_cost_ff, rsp_cost_in;
   logic rsp_done_ff, rsp_done_in;
   logic [COST_WIDTH-1:0] same_ff, upper_raw_ff;

   logic [COUNT_WIDTH-1:0] count_ext, eff_count, disp_next;
   logic [IW-1:0] upper_addr;
   logic upper_ok, out_free, req_take, calc_fire;
   logic [COST_WIDTH-1:0] gray_diff, upper, result;
   logic [DIVISOR_WIDTH:0] rem_shift, rem_sub;
   logic quo_bit;
   logic [P2_WIDTH-1:0] jump;
   logic [P2_WIDTH:0] cand_jump, m_ab, m_cd, m_all;
   logic [COST_WIDTH:0] cand_lower, cand_upper;

   always_comb begin
      count_ext = {1'b0, count_ff};
      if (count_ext == '0) begin
         eff_count = COUNT_WIDTH'(1);
      end else if (count_ext > COUNT_WIDTH'(MAX_DISPARITIES)) begin
         eff_count = COUNT_WIDTH'(MAX_DISPARITIES);
      end else begin
         eff_count = count_ext;
      end
      disp_next = COUNT_WIDTH'(disp_ff) + COUNT_WIDTH'(1);
      upper_ok = disp_next < eff_count;
      upper_addr = disp_next[IW-1:0];
   end

   always_ff @(posedge clock) begin
      same_ff <= cost_mem[disp_ff];
      upper_raw_ff <= cost_mem[upper_addr];
      if (calc_fire) begin
         cost_mem[disp_ff] <= result;
      end
   end

   always_comb begin
      gray_diff = (req_pixel_gray > prev_gray_ff) ? (req_pixel_gray - prev_gray_ff)
                                                  : (prev_gray_ff - req_pixel_gray);
      rem_shift = {rem_ff, quo_ff[P2_WIDTH-1]};
      rem_sub = rem_shift - {1'b0, divisor_ff};
      quo_bit = rem_shift >= {1'b0, divisor_ff};

      upper = upper_ok ? upper_raw_ff : COST_TOP;
      jump = (large_pen_ff > P2_WIDTH'(small_penalty_ff)) ? large_pen_ff
                                                          : P2_WIDTH'(small_penalty_ff);
      cand_jump = (P2_WIDTH + 1)'(prev_min_ff) + (P2_WIDTH + 1)'(jump);
      cand_lower = (COST_WIDTH + 1)'(held_lower_ff) + (COST_WIDTH + 1)'(small_penalty_ff);
      cand_upper = (COST_WIDTH + 1)'(upper) + (COST_WIDTH + 1)'(small_penalty_ff);
      m_ab = ((COST_WIDTH + 1)'(same_ff) < cand_lower) ? (P2_WIDTH + 1)'(same_ff)
                                                        : (P2_WIDTH + 1)'(cand_lower);
      m_cd = ((P2_WIDTH + 1)'(cand_upper) < cand_jump) ? (P2_WIDTH + 1)'(cand_upper)
                                                        : cand_jump;
      m_all = (m_ab < m_cd) ? m_ab : m_cd;
      result = first_ff ? cost_ff : (cost_ff + m_all[COST_WIDTH-1:0] - prev_min_ff);

      out_free = !rsp_valid_ff || rsp_ready;
      req_take = (state_ff == ST_IDLE) && req_valid;
      calc_fire = (state_ff == ST_CALC) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      small_penalty_in = small_penalty_ff;
      large_base_in = large_base_ff;
      count_in = count_ff;
      prev_min_in = prev_min_ff;
      run_min_in = run_min_ff;
      held_lower_in = held_lower_ff;
      prev_gray_in = prev_gray_ff;
      large_pen_in = large_pen_ff;
      disp_in = disp_ff;
      first_in = first_ff;
      cost_in = cost_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cost_in = rsp_cost_ff;
      rsp_done_in = rsp_done_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_SMALL_PENALTY: small_penalty_in = csr_data[COST_WIDTH-1:0];
            CSR_LARGE_PENALTY_BASE: large_base_in = csr_data;
            CSR_DISPARITY_COUNT: count_in = csr_data[COST_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cost_in = req_initial_cost;
               if (disp_ff == '0) begin
                  first_in = req_path_start;
                  prev_gray_in = req_pixel_gray;
                  held_lower_in = COST_TOP;
                  divisor_in = {1'b0, gray_diff} + DIVISOR_WIDTH'(1);
                  rem_in = '0;
                  quo_in = large_base_ff;
                  step_in = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_DIV: begin
            rem_in = quo_bit ? rem_sub[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[P2_WIDTH-2:0], quo_bit};
            step_in = step_ff + DIV_STEP_WIDTH'(1);
            if (step_ff == DIV_LAST_STEP) begin
               large_pen_in = {quo_ff[P2_WIDTH-2:0], quo_bit};
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in = result;
               rsp_done_in = !upper_ok;
               held_lower_in = same_ff;
               if (!upper_ok) begin
                  prev_min_in = (result < run_min_ff) ? result : run_min_ff;
                  run_min_in = COST_TOP;
                  disp_in = '0;
               end else begin
                  run_min_in = (result < run_min_ff) ? result : run_min_ff;
                  disp_in = disp_ff + IW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         small_penalty_ff <= SMALL_PENALTY_RESET;
         large_base_ff <= LARGE_PENALTY_RESET;
         count_ff <= COUNT_RESET;
         prev_min_ff <= COST_TOP;
         run_min_ff <= COST_TOP;
         held_lower_ff <= COST_TOP;
         prev_gray_ff <= '0;
         large_pen_ff <= '0;
         disp_ff <= '0;
         first_ff <= 1'b1;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         small_penalty_ff <= small_penalty_in;
         large_base_ff <= large_base_in;
         count_ff <= count_in;
         prev_min_ff <= prev_min_in;
         run_min_ff <= run_min_in;
         held_lower_ff <= held_lower_in;
         prev_gray_ff <= prev_gray_in;
         large_pen_ff <= large_pen_in;
         disp_ff <= disp_in;
         first_ff <= first_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff <= cost_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_aggregated_cost = rsp_cost_ff;
   assign rsp_pixel_done = rsp_done_ff;

endmodule

/* rtl/core/sgmpca_checker.sv */
`include "sgm_path_cost_aggregation_unit_macros.svh"

module sgmpca_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [7:0]             rsp_aggregated_cost,
   input logic                   rsp_pixel_done
);

   logic rsp_stall;
   logic req_accept;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_accept = req_valid && req_ready;

   `SGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_aggregated_cost) && $stable(rsp_pixel_done))
   `SGM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_ready)
   `SGM_ASSERT_SAME(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind sgm_path_cost_aggregation_unit sgmpca_checker u_sgmpca_checker (.*);
